// ===== design/swm_pkg.sv =====
// Package for the stack with multipop: operation kinds, status codes,
// shift commands for the storage chain and the controller state type.
// No dependencies.
`default_nettype none

package swm_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned COST_W  = 32;

    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MPOP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_PUSHED    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_POPPED    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTHING   = 3'd4;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_PUSH = 2'd1,
        SH_POP  = 2'd2
    } t_shift;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_MPOP = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ===== design/swm_cell.sv =====
// One storage cell of the stack chain: holds one word, takes the word from
// above on push and the word from below on pop. Depends on swm_pkg.
`default_nettype none

module swm_cell (
    input  wire logic                               i_clk,
    input  wire swm_pkg::t_shift                    i_shift,
    input  wire logic signed [swm_pkg::WORD_W-1:0]  i_from_above,
    input  wire logic signed [swm_pkg::WORD_W-1:0]  i_from_below,
    output logic signed [swm_pkg::WORD_W-1:0]       o_word
);

    logic signed [swm_pkg::WORD_W-1:0] r_word;
    logic signed [swm_pkg::WORD_W-1:0] n_word;

    always_comb begin
        unique case (i_shift)
            swm_pkg::SH_PUSH: n_word = i_from_above;
            swm_pkg::SH_POP:  n_word = i_from_below;
            default:          n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== design/stack_with_multipop_unit.sv =====
// Top level of the stack with multipop: controller, cost counter, output
// register and a chain of swm_cell storage cells. Depends on swm_pkg, swm_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries kind, push_value and
//   pop_count. Output channel (o_out_valid / i_out_stall) carries status,
//   popped_value, last, now_empty and op_cost for each result.
//   Push and pop give one result in the cycle after the transfer, and a new
//   item can be taken every cycle while the output is not stalled. A multipop
//   of n words gives n results, one per cycle unless the output stalls, the
//   first in the cycle after the transfer; the input stalls until the last
//   word is popped, as the chain shifts one word per cycle. A multipop that
//   pops nothing gives a single result. Kind three is taken and gives no
//   result. The top of the stack sits in cell zero; every successful push or
//   pop, and each word of a multipop, shifts the whole chain by one cell.
//   Reset empties the stack, clears the cost counter and drops any pending
//   result. While the receiver stalls, the pending result holds and the block
//   takes no new item and pops nothing further.
`default_nettype none

module stack_with_multipop_unit #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [swm_pkg::KIND_W-1:0]          i_kind,
    input  wire logic signed [swm_pkg::WORD_W-1:0]   i_push_value,
    input  wire logic [swm_pkg::COUNT_W-1:0]         i_pop_count,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [swm_pkg::STAT_W-1:0]               o_status,
    output logic signed [swm_pkg::WORD_W-1:0]        o_popped_value,
    output logic                                     o_last,
    output logic                                     o_now_empty,
    output logic [swm_pkg::COST_W-1:0]               o_op_cost
);

    localparam int unsigned FILL_W = $clog2(DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

    swm_pkg::t_state                      r_state, n_state;
    logic [FILL_W-1:0]                    r_fill, n_fill;
    logic [swm_pkg::COUNT_W-1:0]          r_want, n_want;
    logic [swm_pkg::COST_W-1:0]           r_cost, n_cost;
    logic                                 r_out_valid;
    logic [swm_pkg::STAT_W-1:0]           r_status, n_status;
    logic signed [swm_pkg::WORD_W-1:0]    r_value, n_value;
    logic                                 r_last, n_last;
    logic                                 r_empty, n_empty;
    logic                                 load_out;
    logic                                 out_free;
    logic                                 in_acc;
    swm_pkg::t_shift                      shift;
    logic [swm_pkg::COST_W-1:0]           cost_inc;
    logic [swm_pkg::COUNT_W-1:0]          want_after;
    logic signed [swm_pkg::WORD_W-1:0]    words [DEPTH];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == swm_pkg::ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cost_inc   = (r_cost != '1) ? r_cost + 1'b1 : r_cost;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_want     = r_want;
        n_cost     = r_cost;
        n_status   = r_status;
        n_value    = '0;
        n_last     = 1'b1;
        n_empty    = (r_fill == '0);
        load_out   = 1'b0;
        shift      = swm_pkg::SH_HOLD;
        want_after = '0;
        if (in_acc) begin
            unique case (i_kind)
                swm_pkg::KIND_PUSH: begin
                    load_out = 1'b1;
                    if (r_fill == FILL_FULL) begin
                        n_status = swm_pkg::STAT_OVERFLOW;
                    end else begin
                        shift    = swm_pkg::SH_PUSH;
                        n_fill   = r_fill + 1'b1;
                        n_cost   = cost_inc;
                        n_status = swm_pkg::STAT_PUSHED;
                        n_empty  = 1'b0;
                    end
                end
                swm_pkg::KIND_POP: begin
                    load_out = 1'b1;
                    if (r_fill == '0) begin
                        n_status = swm_pkg::STAT_UNDERFLOW;
                    end else begin
                        shift    = swm_pkg::SH_POP;
                        n_fill   = r_fill - 1'b1;
                        n_cost   = cost_inc;
                        n_status = swm_pkg::STAT_POPPED;
                        n_value  = words[0];
                        n_empty  = (n_fill == '0);
                    end
                end
                swm_pkg::KIND_MPOP: begin
                    load_out = 1'b1;
                    if (r_fill == '0 || i_pop_count == '0) begin
                        n_status = swm_pkg::STAT_NOTHING;
                    end else begin
                        shift      = swm_pkg::SH_POP;
                        n_fill     = r_fill - 1'b1;
                        n_cost     = cost_inc;
                        n_status   = swm_pkg::STAT_POPPED;
                        n_value    = words[0];
                        n_empty    = (n_fill == '0);
                        want_after = i_pop_count - 1'b1;
                        n_want     = want_after;
                        n_last     = (n_fill == '0) || (want_after == '0);
                        if (!n_last) begin
                            n_state = swm_pkg::ST_MPOP;
                        end
                    end
                end
                default: begin
                    load_out = 1'b0;
                end
            endcase
        end else if (r_state == swm_pkg::ST_MPOP && out_free) begin
            load_out   = 1'b1;
            shift      = swm_pkg::SH_POP;
            n_fill     = r_fill - 1'b1;
            n_cost     = cost_inc;
            n_status   = swm_pkg::STAT_POPPED;
            n_value    = words[0];
            n_empty    = (n_fill == '0);
            want_after = r_want - 1'b1;
            n_want     = want_after;
            n_last     = (n_fill == '0) || (want_after == '0);
            if (n_last) begin
                n_state = swm_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swm_pkg::ST_IDLE;
            r_fill      <= '0;
            r_want      <= '0;
            r_cost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_want  <= n_want;
            r_cost  <= n_cost;
            if (out_free) begin
                r_out_valid <= load_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_last   <= n_last;
            r_empty  <= n_empty;
        end
    end

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [swm_pkg::WORD_W-1:0] above;
            logic signed [swm_pkg::WORD_W-1:0] below;
            if (g == 0) begin : g_top
                assign above = i_push_value;
            end else begin : g_mid
                assign above = words[g-1];
            end
            if (g == DEPTH - 1) begin : g_bot
                assign below = '0;
            end else begin : g_inner
                assign below = words[g+1];
            end
            swm_cell u_cell (
                .i_clk        (i_clk),
                .i_shift      (shift),
                .i_from_above (above),
                .i_from_below (below),
                .o_word       (words[g])
            );
        end
    endgenerate

    logic [swm_pkg::COST_W-1:0] r_cost_out;

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_cost_out <= n_cost;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_value;
    assign o_last         = r_last;
    assign o_now_empty    = r_empty;
    assign o_op_cost      = r_cost_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill level beyond depth");

    a_mpop_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swm_pkg::ST_MPOP) |-> (r_fill != '0 && r_want != '0))
        else $error("multipop running with nothing to pop");

    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == swm_pkg::KIND_PUSH) |=> o_out_valid)
        else $error("push transfer gave no result");

endmodule

`default_nettype wire

// ===== dv/tb_stack_with_multipop_unit.sv =====
// Self-checking testbench for stack_with_multipop_unit: push, pop and multipop
// traffic with random stalls on both channels, checked against a LIFO predictor.
// Depends on swm_pkg and the stack_with_multipop_unit RTL.
`default_nettype none

module tb_stack_with_multipop_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_OPS   = 40;
    localparam logic [swm_pkg::KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam logic [swm_pkg::COST_W-1:0] COST_MAX     = '1;

    typedef struct {
        logic [swm_pkg::KIND_W-1:0]         kind;
        logic signed [swm_pkg::WORD_W-1:0]  value;
        logic [swm_pkg::COUNT_W-1:0]        count;
    } t_stack_op;

    typedef struct {
        logic [swm_pkg::STAT_W-1:0]         status;
        logic signed [swm_pkg::WORD_W-1:0]  value;
        logic                               is_last;
        logic                               now_empty;
        logic [swm_pkg::COST_W-1:0]         cost;
    } t_stack_result;

    logic                                i_clk        = 1'b0;
    logic                                i_rst_n      = 1'b0;
    logic                                i_in_valid   = 1'b0;
    logic                                o_in_stall;
    logic [swm_pkg::KIND_W-1:0]          i_kind       = swm_pkg::KIND_PUSH;
    logic signed [swm_pkg::WORD_W-1:0]   i_push_value = '0;
    logic [swm_pkg::COUNT_W-1:0]         i_pop_count  = '0;
    logic                                o_out_valid;
    logic                                i_out_stall  = 1'b0;
    logic [swm_pkg::STAT_W-1:0]          o_status;
    logic signed [swm_pkg::WORD_W-1:0]   o_popped_value;
    logic                                o_last;
    logic                                o_now_empty;
    logic [swm_pkg::COST_W-1:0]          o_op_cost;

    t_stack_op      pending_ops[$];
    t_stack_result  expected_results[$];
    t_stack_op      cur_op;

    logic signed [swm_pkg::WORD_W-1:0] held_words [DEPTH];
    int unsigned    held_count = 0;
    logic [swm_pkg::COST_W-1:0] cost_count = '0;

    int  mismatches;
    int  ops_done;
    int  results_seen;
    int  status_hits [5];
    int  in_stall_cycles;
    int  longest_mpop;
    int  send_gap;
    int  rx_gap;
    int  hold_left;
    int  idle_cycles;
    int  plan_level;
    int  random_queued;
    bit  calm;
    bit  hold_req;
    bit  hold_done;

    stack_with_multipop_unit #(.DEPTH(DEPTH)) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_push_value   (i_push_value),
        .i_pop_count    (i_pop_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_last         (o_last),
        .o_now_empty    (o_now_empty),
        .o_op_cost      (o_op_cost)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string field, input int idx,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s got 0x%08h want 0x%08h",
                                    idx, field, got, want));
    endtask

    function automatic void bump_cost();
        if (cost_count != COST_MAX)
            cost_count++;
    endfunction

    function automatic void add_result(input logic [swm_pkg::STAT_W-1:0] status,
                                       input logic signed [swm_pkg::WORD_W-1:0] value,
                                       input logic is_last);
        t_stack_result r;
        r.status    = status;
        r.value     = value;
        r.is_last   = is_last;
        r.now_empty = (held_count == 0);
        r.cost      = cost_count;
        expected_results.push_back(r);
        status_hits[status]++;
    endfunction

    function automatic void predict_stack_op(input t_stack_op op);
        int unsigned want;
        int unsigned popped;
        popped = 0;
        case (op.kind)
            swm_pkg::KIND_PUSH: begin
                if (held_count >= DEPTH) begin
                    add_result(swm_pkg::STAT_OVERFLOW, '0, 1'b1);
                end else begin
                    held_words[held_count] = op.value;
                    held_count++;
                    bump_cost();
                    add_result(swm_pkg::STAT_PUSHED, '0, 1'b1);
                end
            end
            swm_pkg::KIND_POP: begin
                if (held_count == 0) begin
                    add_result(swm_pkg::STAT_UNDERFLOW, '0, 1'b1);
                end else begin
                    held_count--;
                    bump_cost();
                    add_result(swm_pkg::STAT_POPPED, held_words[held_count], 1'b1);
                end
            end
            swm_pkg::KIND_MPOP: begin
                want = 32'(op.count);
                if (held_count == 0 || want == 0) begin
                    add_result(swm_pkg::STAT_NOTHING, '0, 1'b1);
                end else begin
                    while (held_count != 0 && want != 0) begin
                        held_count--;
                        want--;
                        popped++;
                        bump_cost();
                        add_result(swm_pkg::STAT_POPPED, held_words[held_count],
                                   held_count == 0 || want == 0);
                    end
                    if (popped > longest_mpop)
                        longest_mpop = popped;
                end
            end
            default: begin
            end
        endcase
        if (op.kind != KIND_IGNORED)
            ops_done++;
    endfunction

    // driver: hold while stalled, advance on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_stall)
                in_stall_cycles++;
            if (i_in_valid && !o_in_stall)
                predict_stack_op(cur_op);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    cur_op = pending_ops.pop_front();
                    i_kind       <= cur_op.kind;
                    i_push_value <= cur_op.value;
                    i_pop_count  <= cur_op.count;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, including the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_gap = 0;
            hold_left = 0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result status %0d value 0x%08h",
                                        o_status, o_popped_value));
            end else begin
                want = expected_results.pop_front();
                check_field("status", results_seen, 32'(o_status), 32'(want.status));
                check_field("popped_value", results_seen, o_popped_value, want.value);
                check_field("last", results_seen, 32'(o_last), 32'(want.is_last));
                check_field("now_empty", results_seen, 32'(o_now_empty),
                            32'(want.now_empty));
                check_field("op_cost", results_seen, o_op_cost, want.cost);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_stack_with_multipop_unit NOT OK");
            $finish;
        end
    end

    function automatic logic signed [swm_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_op(input logic [swm_pkg::KIND_W-1:0] kind,
                                   input logic signed [swm_pkg::WORD_W-1:0] value,
                                   input logic [swm_pkg::COUNT_W-1:0] count);
        t_stack_op op;
        op.kind  = kind;
        op.value = value;
        op.count = count;
        pending_ops.push_back(op);
        case (kind)
            swm_pkg::KIND_PUSH: if (plan_level < DEPTH) plan_level++;
            swm_pkg::KIND_POP:  if (plan_level > 0) plan_level--;
            swm_pkg::KIND_MPOP: plan_level = (count >= plan_level) ? 0 : plan_level - count;
            default: begin
            end
        endcase
        if (kind != KIND_IGNORED)
            random_queued++;
    endfunction

    function automatic logic [swm_pkg::COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'(DEPTH);
            3:       return 7'(plan_level);
            4:       return 7'(plan_level + $urandom_range(1, 4));
            default: return 7'($urandom_range(1, DEPTH));
        endcase
    endfunction

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0);
    endtask

    initial begin
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_op(swm_pkg::KIND_PUSH, 32'h7fff_ffff, 7'd0);
        add_op(swm_pkg::KIND_PUSH, 32'h8000_0000, 7'd64);
        add_op(swm_pkg::KIND_PUSH, 32'hffff_ffff, 7'd127);
        add_op(swm_pkg::KIND_PUSH, 32'h0000_0000, 7'd0);
        add_op(swm_pkg::KIND_PUSH, 32'h5555_aaaa, 7'd0);
        add_op(swm_pkg::KIND_POP, 32'hffff_ffff, 7'd127);
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd2);
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd0);
        add_op(KIND_IGNORED, 32'hffff_ffff, 7'd64);
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd64);
        add_op(swm_pkg::KIND_POP, 32'h0, 7'd0);
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd3);
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd0);
        add_op(swm_pkg::KIND_PUSH, 32'haaaa_5555, 7'd0);
        add_op(swm_pkg::KIND_PUSH, 32'h0000_0001, 7'd0);
        add_op(swm_pkg::KIND_PUSH, 32'hffff_fffe, 7'd0);
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd1);
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd2);
        add_op(KIND_IGNORED, 32'h0, 7'd0);
        add_op(swm_pkg::KIND_POP, 32'h0, 7'd0);
        wait_drained();

        // fill to overflow behind a long receiver hold-off, then drain at once
        hold_req = 1'b1;
        for (int i = 0; i < DEPTH + 3; i++)
            add_op(swm_pkg::KIND_PUSH, $urandom, 7'($urandom_range(0, DEPTH)));
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd64);
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd64);
        wait_drained();

        random_queued = 0;
        while (random_queued < RANDOM_OPS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    n = $urandom_range(1, 12);
                    repeat (n) add_op(swm_pkg::KIND_PUSH, pick_word(),
                                      7'($urandom_range(0, DEPTH)));
                end
                5, 6: begin
                    n = $urandom_range(1, 4);
                    repeat (n) add_op(swm_pkg::KIND_POP, $urandom,
                                      7'($urandom_range(0, DEPTH)));
                end
                7, 8: add_op(swm_pkg::KIND_MPOP, $urandom, pick_count());
                default: add_op(2'($urandom_range(0, 3)), $urandom,
                                7'($urandom_range(0, DEPTH)));
            endcase
        end
        wait_drained();

        calm = 1'b1;
        for (int i = 0; i < 20; i++) begin
            case ($urandom_range(0, 3))
                0, 1:    add_op(swm_pkg::KIND_PUSH, pick_word(), 7'd0);
                2:       add_op(swm_pkg::KIND_POP, 32'h0, 7'd0);
                default: add_op(swm_pkg::KIND_MPOP, 32'h0, pick_count());
            endcase
        end
        add_op(swm_pkg::KIND_MPOP, 32'h0, 7'd64);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("ran %0d operations giving %0d results: %0d pushed, %0d popped, %0d overflow,",
                 ops_done, results_seen, status_hits[swm_pkg::STAT_PUSHED],
                 status_hits[swm_pkg::STAT_POPPED], status_hits[swm_pkg::STAT_OVERFLOW]);
        $display("%0d underflow, %0d empty multipops; longest multipop %0d; stalled %0d cycles",
                 status_hits[swm_pkg::STAT_UNDERFLOW], status_hits[swm_pkg::STAT_NOTHING],
                 longest_mpop, in_stall_cycles);
        if (mismatches == 0)
            $display("tb_stack_with_multipop_unit OK");
        else
            $display("tb_stack_with_multipop_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== stack_with_multipop_unit.f =====
design/swm_pkg.sv
design/swm_cell.sv
design/stack_with_multipop_unit.sv
dv/tb_stack_with_multipop_unit.sv
